// File: hw/rtl/gcg_pkg.sv
// Shared constants of the Gold code chip generator: seed, mixing and register codes.
package gcg_pkg;

   localparam logic [31:0] SEED_ONE_INIT = 32'h6A09E667;
   localparam logic [31:0] SEED_TWO_INIT = 32'hBB67AE85;
   localparam logic [63:0] MIX_GAMMA     = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A     = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B     = 64'h94D049BB133111EB;

   localparam int          PAYLOAD_LEN   = 49;
   localparam logic [5:0]  PAYLOAD_LAST  = 6'(PAYLOAD_LEN - 1);

   localparam int          DIGIT_WIDTH   = 4;
   localparam int          MUL_STEPS     = 64 / DIGIT_WIDTH;

   localparam logic [2:0]  REG_KEY_LOW    = 3'd0;
   localparam logic [2:0]  REG_KEY_HIGH   = 3'd1;
   localparam logic [2:0]  REG_KEY_LENGTH = 3'd2;
   localparam logic [2:0]  REG_AI_FLAG    = 3'd3;
   localparam logic [2:0]  REG_TIMESTAMP  = 3'd4;
   localparam logic [2:0]  REG_MODEL_ID   = 3'd5;

   localparam logic [1:0]  PASS_GAMMA = 2'd0;
   localparam logic [1:0]  PASS_MUL_A = 2'd1;
   localparam logic [1:0]  PASS_MUL_B = 2'd2;

endpackage

// File: hw/rtl/gold_code_chip_generator_core.sv
// Gold code chip generator: two 31-bit LFSRs, payload modulation, serial reseed engine.
//
// One beat in gives one chip beat out. A beat with req_new_frame low steps the
// LFSRs at once and registers its chip. A beat with req_new_frame high first runs
// the seed mixer over the key bytes, the key length clipped to MAX_KEY_BYTES,
// then three 64-bit multiplies of the splitmix finalizer, each run on one shared
// shift-and-add unit at 4 bits of multiplier per cycle plus a mix step, before
// the chip is made. Registers are written over the APB port at byte address 8*i and
// should change only while no beat is in flight.
module gold_code_chip_generator_core #(
   parameter int MAX_KEY_BYTES = 16,
   parameter int CHIPS_PER_BIT = 8,
   parameter int MAX_CHIPS     = 32768
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_new_frame,
   input  logic [31:0] req_frame_index,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_chip_bit,
   output logic        rsp_raw_chip_bit,
   output logic [5:0]  rsp_payload_bit_index,
   output logic        rsp_is_pilot,
   output logic [14:0] rsp_chip_index,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_KEY  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_MIX  = 3'd3;
   localparam logic [2:0] ST_CHIP = 3'd4;

   localparam logic [4:0]  KEY_LIMIT   = 5'(MAX_KEY_BYTES);
   localparam logic [14:0] CHIP_TOP    = 15'(MAX_CHIPS - 1);
   localparam logic [14:0] PILOT_START = 15'(gcg_pkg::PAYLOAD_LEN * CHIPS_PER_BIT);
   localparam logic [3:0]  STEP_LAST   = 4'(gcg_pkg::MUL_STEPS - 1);

   logic [63:0] key_low_ff, key_low_in;
   logic [63:0] key_high_ff, key_high_in;
   logic [4:0]  key_length_ff, key_length_in;
   logic        ai_flag_ff, ai_flag_in;
   logic [31:0] timestamp_ff, timestamp_in;
   logic [15:0] model_id_ff, model_id_in;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  byte_cnt_ff, byte_cnt_in;
   logic [3:0]  step_ff, step_in;
   logic [1:0]  pass_ff, pass_in;
   logic [31:0] s1_ff, s1_in;
   logic [31:0] s2_ff, s2_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] mcand_ff, mcand_in;
   logic [63:0] mplier_ff, mplier_in;

   logic [31:0] lfsr_one_ff, lfsr_one_in;
   logic [31:0] lfsr_two_ff, lfsr_two_in;
   logic [14:0] chip_counter_ff, chip_counter_in;
   logic [5:0]  pidx_ff, pidx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        chip_ff, chip_in;
   logic        raw_ff, raw_in;
   logic [5:0]  out_pidx_ff, out_pidx_in;
   logic        pilot_ff, pilot_in;
   logic [14:0] out_idx_ff, out_idx_in;

   logic        cfg_write;
   logic        out_busy;
   logic        req_take;
   logic        gen;
   logic [4:0]  key_count;
   logic [7:0]  key_byte;
   logic [31:0] x1;
   logic [31:0] x2;
   logic [67:0] partial;
   logic [63:0] z;
   logic        b1;
   logic        b2;
   logic        raw;
   logic        pilot;
   logic        pay_bit;
   logic [48:0] payload_word;
   logic [5:0]  pay_sel;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign out_busy  = rsp_valid_ff & rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) | out_busy;
   assign req_take  = req_valid & ~req_stall;
   assign gen       = (req_take & ~req_new_frame) | ((state_ff == ST_CHIP) & ~out_busy);

   assign key_count = (key_length_ff > KEY_LIMIT) ? KEY_LIMIT : key_length_ff;
   assign key_byte  = byte_cnt_ff[3] ? key_high_ff[{byte_cnt_ff[2:0], 3'b000} +: 8]
                                     : key_low_ff[{byte_cnt_ff[2:0], 3'b000} +: 8];
   assign x1 = s1_ff ^ (32'(key_byte) << {byte_cnt_ff[1:0], 3'b000});
   assign x2 = s2_ff ^ (32'(key_byte) << {2'(byte_cnt_ff[1:0] + 2'd1), 3'b000});

   assign partial = {4'b0000, mcand_ff} *
                    {64'd0, mplier_ff[gcg_pkg::DIGIT_WIDTH-1:0]};

   assign b1  = lfsr_one_ff[30] ^ lfsr_one_ff[2];
   assign b2  = lfsr_two_ff[30] ^ lfsr_two_ff[12];
   assign raw = b1 ^ b2;
   assign pilot        = (chip_counter_ff >= PILOT_START);
   assign payload_word = {ai_flag_ff, timestamp_ff, model_id_ff};
   assign pay_sel      = gcg_pkg::PAYLOAD_LAST - pidx_ff;
   assign pay_bit      = payload_word[pay_sel];

   always_comb begin
      unique case (pass_ff)
         gcg_pkg::PASS_GAMMA: z = {s1_ff, s2_ff} + acc_ff;
         gcg_pkg::PASS_MUL_A: z = acc_ff;
         default:             z = acc_ff ^ (acc_ff >> 31);
      endcase
   end

   always_comb begin
      key_low_in    = key_low_ff;
      key_high_in   = key_high_ff;
      key_length_in = key_length_ff;
      ai_flag_in    = ai_flag_ff;
      timestamp_in  = timestamp_ff;
      model_id_in   = model_id_ff;
      if (cfg_write) begin
         unique case (paddr[5:3])
            gcg_pkg::REG_KEY_LOW:    key_low_in    = pwdata;
            gcg_pkg::REG_KEY_HIGH:   key_high_in   = pwdata;
            gcg_pkg::REG_KEY_LENGTH: key_length_in = pwdata[4:0];
            gcg_pkg::REG_AI_FLAG:    ai_flag_in    = pwdata[0];
            gcg_pkg::REG_TIMESTAMP:  timestamp_in  = pwdata[31:0];
            gcg_pkg::REG_MODEL_ID:   model_id_in   = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[5:3])
         gcg_pkg::REG_KEY_LOW:    prdata = key_low_ff;
         gcg_pkg::REG_KEY_HIGH:   prdata = key_high_ff;
         gcg_pkg::REG_KEY_LENGTH: prdata = {59'd0, key_length_ff};
         gcg_pkg::REG_AI_FLAG:    prdata = {63'd0, ai_flag_ff};
         gcg_pkg::REG_TIMESTAMP:  prdata = {32'd0, timestamp_ff};
         gcg_pkg::REG_MODEL_ID:   prdata = {48'd0, model_id_ff};
         default:                 prdata = 64'd0;
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      byte_cnt_in     = byte_cnt_ff;
      step_in         = step_ff;
      pass_in         = pass_ff;
      s1_in           = s1_ff;
      s2_in           = s2_ff;
      acc_in          = acc_ff;
      mcand_in        = mcand_ff;
      mplier_in       = mplier_ff;
      lfsr_one_in     = lfsr_one_ff;
      lfsr_two_in     = lfsr_two_ff;
      chip_counter_in = chip_counter_ff;
      pidx_in         = pidx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_new_frame) begin
               state_in    = ST_KEY;
               byte_cnt_in = 5'd0;
               s1_in       = gcg_pkg::SEED_ONE_INIT;
               s2_in       = gcg_pkg::SEED_TWO_INIT;
               mplier_in   = {32'd0, req_frame_index};
            end
         end
         ST_KEY: begin
            if (byte_cnt_ff < key_count) begin
               s1_in       = {x1[24:0], x1[31:25]};
               s2_in       = {x2[18:0], x2[31:19]};
               byte_cnt_in = byte_cnt_ff + 5'd1;
            end else begin
               s1_in    = (s1_ff == 32'd0) ? 32'd1 : s1_ff;
               s2_in    = (s2_ff == 32'd0) ? 32'd1 : s2_ff;
               acc_in   = 64'd0;
               mcand_in = gcg_pkg::MIX_GAMMA;
               step_in  = 4'd0;
               pass_in  = gcg_pkg::PASS_GAMMA;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in    = acc_ff + partial[63:0];
            mcand_in  = {mcand_ff[63-gcg_pkg::DIGIT_WIDTH:0], {gcg_pkg::DIGIT_WIDTH{1'b0}}};
            mplier_in = {{gcg_pkg::DIGIT_WIDTH{1'b0}}, mplier_ff[63:gcg_pkg::DIGIT_WIDTH]};
            step_in   = step_ff + 4'd1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            acc_in  = 64'd0;
            step_in = 4'd0;
            unique case (pass_ff)
               gcg_pkg::PASS_GAMMA: begin
                  mcand_in  = z ^ (z >> 30);
                  mplier_in = gcg_pkg::MIX_MUL_A;
                  pass_in   = gcg_pkg::PASS_MUL_A;
                  state_in  = ST_MUL;
               end
               gcg_pkg::PASS_MUL_A: begin
                  mcand_in  = z ^ (z >> 27);
                  mplier_in = gcg_pkg::MIX_MUL_B;
                  pass_in   = gcg_pkg::PASS_MUL_B;
                  state_in  = ST_MUL;
               end
               default: begin
                  lfsr_one_in     = (z[63:32] == 32'd0) ? 32'd1 : z[63:32];
                  lfsr_two_in     = (z[31:0] == 32'd0) ? 32'd1 : z[31:0];
                  chip_counter_in = 15'd0;
                  pidx_in         = 6'd0;
                  state_in        = ST_CHIP;
               end
            endcase
         end
         ST_CHIP: begin
            if (!out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (gen) begin
         lfsr_one_in = {lfsr_one_ff[30:0], b1};
         lfsr_two_in = {lfsr_two_ff[30:0], b2};
         if (chip_counter_ff < CHIP_TOP) begin
            chip_counter_in = chip_counter_ff + 15'd1;
            pidx_in         = (pidx_ff == gcg_pkg::PAYLOAD_LAST) ? 6'd0 : pidx_ff + 6'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      chip_in      = chip_ff;
      raw_in       = raw_ff;
      out_pidx_in  = out_pidx_ff;
      pilot_in     = pilot_ff;
      out_idx_in   = out_idx_ff;
      if (gen) begin
         rsp_valid_in = 1'b1;
         chip_in      = pilot ? raw : ~(raw ^ pay_bit);
         raw_in       = raw;
         out_pidx_in  = pidx_ff;
         pilot_in     = pilot;
         out_idx_in   = chip_counter_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff      <= 64'd0;
         key_high_ff     <= 64'd0;
         key_length_ff   <= 5'd16;
         ai_flag_ff      <= 1'b1;
         timestamp_ff    <= 32'd0;
         model_id_ff     <= 16'd0;
         state_ff        <= ST_IDLE;
         byte_cnt_ff     <= 5'd0;
         step_ff         <= 4'd0;
         pass_ff         <= gcg_pkg::PASS_GAMMA;
         lfsr_one_ff     <= 32'd1;
         lfsr_two_ff     <= 32'd1;
         chip_counter_ff <= 15'd0;
         pidx_ff         <= 6'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         key_low_ff      <= key_low_in;
         key_high_ff     <= key_high_in;
         key_length_ff   <= key_length_in;
         ai_flag_ff      <= ai_flag_in;
         timestamp_ff    <= timestamp_in;
         model_id_ff     <= model_id_in;
         state_ff        <= state_in;
         byte_cnt_ff     <= byte_cnt_in;
         step_ff         <= step_in;
         pass_ff         <= pass_in;
         lfsr_one_ff     <= lfsr_one_in;
         lfsr_two_ff     <= lfsr_two_in;
         chip_counter_ff <= chip_counter_in;
         pidx_ff         <= pidx_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      chip_ff     <= chip_in;
      raw_ff      <= raw_in;
      out_pidx_ff <= out_pidx_in;
      pilot_ff    <= pilot_in;
      out_idx_ff  <= out_idx_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_chip_bit          = chip_ff;
   assign rsp_raw_chip_bit      = raw_ff;
   assign rsp_payload_bit_index = out_pidx_ff;
   assign rsp_is_pilot          = pilot_ff;
   assign rsp_chip_index        = out_idx_ff;

endmodule
